// ===== hdl/ppad_pkg.sv =====
// Shared widths, status codes and controller/datapath handshake types.
`timescale 1ns / 1ps
`default_nettype none
package ppad_pkg;

  // Field widths
  localparam int COORD_W  = 24;             // vertex and point coordinates
  localparam int DIR_W    = COORD_W + 1;    // coordinate differences
  localparam int MAG_W    = COORD_W;        // magnitude of a difference
  localparam int DIST_W   = 32;             // running length and target
  localparam int LEN_W    = 25;             // one segment length
  localparam int SQ_W     = 2 * MAG_W + 1;  // dx*dx + dy*dy
  localparam int PROD_W   = 2 * MAG_W + 1;  // rounded interpolation dividend
  localparam int QUO_W    = MAG_W;          // interpolation offset magnitude
  localparam int STATUS_W = 2;
  localparam int SEEN_W   = 2;

  // Iteration counts of the shared units
  localparam int SQRT_STEPS = (SQ_W + 1) / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int DIV_CNT_W  = $clog2(QUO_W);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLAMPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd2;

  // Vertices seen in the open polyline, saturating
  localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_MAX  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic        [DIST_W-1:0]  dist_t;
  typedef logic        [LEN_W-1:0]   len_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic start_line;  // open a new polyline at the latched vertex
    logic diff;        // form the segment difference
    logic square;      // square the difference magnitudes
    logic root_start;  // launch the segment length root
    logic decide;      // capture the interpolation numerator
    logic mul;         // multiply numerator by the magnitudes
    logic div_start;   // launch both interpolation divisions
    logic hit;         // store the interpolated point
    logic commit;      // advance previous vertex and running length
    logic emit_one;    // load a single-vertex result
    logic emit;        // load a found or clamped result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic open_line;   // item continues an open polyline
    logic last;        // item closes the polyline
    logic hit;         // this segment passes the target
    logic root_busy;
    logic div_busy;
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/ppad_in_if.sv =====
// Input channel: one polyline vertex per item.
`timescale 1ns / 1ps
`default_nettype none
interface ppad_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [ppad_pkg::COORD_W-1:0] vertex_x;
  logic signed [ppad_pkg::COORD_W-1:0] vertex_y;
  logic        [ppad_pkg::DIST_W-1:0]  target_distance;
  logic                          first_vertex;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, target_distance, first_vertex,
                  last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, target_distance, first_vertex,
                last_vertex, output ready);
endinterface
`default_nettype wire

// ===== hdl/ppad_out_if.sv =====
// Result channel: point at the target distance, direction and status.
`timescale 1ns / 1ps
`default_nettype none
interface ppad_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppad_pkg::COORD_W-1:0]  point_x;
  logic signed [ppad_pkg::COORD_W-1:0]  point_y;
  logic signed [ppad_pkg::DIR_W-1:0]    dir_x;
  logic signed [ppad_pkg::DIR_W-1:0]    dir_y;
  logic        [ppad_pkg::STATUS_W-1:0] status;

  modport source (output valid, point_x, point_y, dir_x, dir_y, status, input ready);
  modport sink (input valid, point_x, point_y, dir_x, dir_y, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/ppad_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ppad_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ppad_pkg::SQ_W-1:0]    radicand,
  output      logic                         busy,
  output      logic [ppad_pkg::LEN_W-1:0]   root
);

  localparam int RAD_W  = 2 * ppad_pkg::SQRT_STEPS;
  localparam int REM_W  = ppad_pkg::LEN_W + 2;
  localparam int WORK_W = REM_W + 2;

  logic [RAD_W-1:0]                rad_r, rad_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic [ppad_pkg::LEN_W-1:0]      root_r, root_nxt;
  logic [ppad_pkg::SQRT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic [WORK_W-1:0]               work;
  logic [WORK_W-1:0]               trial;
  logic                            ge;

  // Bring down the next bit pair and try the next root bit
  assign work  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = WORK_W'({root_r, 2'b01});
  assign ge    = work >= trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? REM_W'(work - trial) : REM_W'(work);
      root_nxt = {root_r[ppad_pkg::LEN_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == ppad_pkg::SQRT_CNT_W'(ppad_pkg::SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Hold the operands; only the busy flag and counter need reset
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== hdl/ppad_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
`timescale 1ns / 1ps
`default_nettype none
module ppad_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ppad_pkg::PROD_W-1:0]  dividend,
  input  wire logic [ppad_pkg::LEN_W-1:0]   divisor,
  output      logic                         busy,
  output      logic [ppad_pkg::QUO_W-1:0]   quotient
);

  localparam int QW = ppad_pkg::QUO_W;
  localparam int LW = ppad_pkg::LEN_W;

  logic [LW-1:0]                  rem_r, rem_nxt;
  logic [QW-1:0]                  quo_r, quo_nxt;
  logic [LW-1:0]                  den_r, den_nxt;
  logic [ppad_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [LW:0]                    shifted;
  logic                           ge;

  // Shift in the next dividend bit and compare against the divisor
  assign shifted = {rem_r, quo_r[QW-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = LW'(dividend[ppad_pkg::PROD_W-1:QW]);
      quo_nxt  = dividend[QW-1:0];
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? LW'(shifted - {1'b0, den_r}) : LW'(shifted);
      quo_nxt  = {quo_r[QW-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == ppad_pkg::DIV_CNT_W'(QW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hdl/ppad_dp.sv =====
// Datapath: polyline state, segment arithmetic, root and divider units, result register.
`timescale 1ns / 1ps
`default_nettype none
module ppad_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ppad_pkg::cmd_t                  cmd,
  output      ppad_pkg::sts_t                  sts,
  input  wire ppad_pkg::coord_t                vertex_x,
  input  wire ppad_pkg::coord_t                vertex_y,
  input  wire ppad_pkg::dist_t                 target_distance,
  input  wire logic                            first_vertex,
  input  wire logic                            last_vertex,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      ppad_pkg::coord_t                point_x,
  output      ppad_pkg::coord_t                point_y,
  output      ppad_pkg::dir_t                  dir_x,
  output      ppad_pkg::dir_t                  dir_y,
  output      logic [ppad_pkg::STATUS_W-1:0]   status
);

  localparam int CW = ppad_pkg::COORD_W;
  localparam int DW = ppad_pkg::DIR_W;
  localparam int MW = ppad_pkg::MAG_W;
  localparam int SW = ppad_pkg::DIST_W;
  localparam int LW = ppad_pkg::LEN_W;
  localparam int QW = ppad_pkg::QUO_W;
  localparam int PW = ppad_pkg::PROD_W;

  // Latched item
  ppad_pkg::coord_t vx_r, vy_r;
  ppad_pkg::dist_t  tgt_r;
  logic             first_r, last_r;

  // Polyline state
  ppad_pkg::coord_t            prev_x_r, prev_y_r;
  ppad_pkg::dist_t             run_r, target_r;
  logic                        found_r;
  ppad_pkg::coord_t            hit_x_r, hit_y_r;
  ppad_pkg::dir_t              hit_dx_r, hit_dy_r;
  logic [ppad_pkg::SEEN_W-1:0] seen_r;

  // Segment working registers
  ppad_pkg::dir_t   dx_r, dy_r;
  logic [2*MW-1:0]  sqx_r, sqy_r;
  ppad_pkg::len_t   num_r;
  logic [PW-1:0]    prod_x_r, prod_y_r;

  // Result register
  logic                          out_valid_r;
  ppad_pkg::coord_t              out_x_r, out_y_r;
  ppad_pkg::dir_t                out_dx_r, out_dy_r;
  logic [ppad_pkg::STATUS_W-1:0] out_st_r;

  logic [MW-1:0]               mag_x, mag_y;
  logic [ppad_pkg::SQ_W-1:0]   sq_sum;
  ppad_pkg::len_t              seg_len;
  logic                        root_busy;
  logic                        div_x_busy, div_y_busy;
  logic [QW-1:0]               quo_x, quo_y;
  logic [SW:0]                 next_wide;
  ppad_pkg::dist_t             next_len;
  logic [PW-1:0]               half_len;
  logic [PW-1:0]               dvd_x, dvd_y;
  ppad_pkg::dir_t              off_x, off_y;
  ppad_pkg::dir_t              hit_x_wide, hit_y_wide;
  ppad_pkg::dist_t             num_wide;

  // Difference magnitudes; never exceed 2^24-1
  assign mag_x = dx_r[DW-1] ? MW'(-dx_r) : MW'(dx_r);
  assign mag_y = dy_r[DW-1] ? MW'(-dy_r) : MW'(dy_r);

  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  // Saturating running length after this segment
  assign next_wide = {1'b0, run_r} + (SW + 1)'(seg_len);
  assign next_len  = next_wide[SW] ? '1 : next_wide[SW-1:0];
  assign num_wide  = target_r - run_r;

  // Round to nearest by adding half the segment length before dividing
  assign half_len = PW'(seg_len >> 1);
  assign dvd_x    = prod_x_r + half_len;
  assign dvd_y    = prod_y_r + half_len;

  // Apply the offset sign of each difference
  assign off_x      = dx_r[DW-1] ? -DW'(quo_x) : DW'(quo_x);
  assign off_y      = dy_r[DW-1] ? -DW'(quo_y) : DW'(quo_y);
  assign hit_x_wide = DW'(prev_x_r) + off_x;
  assign hit_y_wide = DW'(prev_y_r) + off_y;

  ppad_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (sq_sum),
    .busy     (root_busy),
    .root     (seg_len)
  );

  ppad_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_x),
    .divisor  (seg_len),
    .busy     (div_x_busy),
    .quotient (quo_x)
  );

  ppad_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_y),
    .divisor  (seg_len),
    .busy     (div_y_busy),
    .quotient (quo_y)
  );

  // Status toward the controller
  always_comb begin
    sts.open_line = !first_r && (seen_r != ppad_pkg::SEEN_NONE);
    sts.last      = last_r;
    sts.hit       = !found_r && (next_len > target_r) && (seg_len != '0);
    sts.root_busy = root_busy;
    sts.div_busy  = div_x_busy || div_y_busy;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Latch the item and the segment working values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r    <= vertex_x;
      vy_r    <= vertex_y;
      tgt_r   <= target_distance;
      first_r <= first_vertex;
      last_r  <= last_vertex;
    end
    if (cmd.diff) begin
      dx_r <= DW'(vx_r) - DW'(prev_x_r);
      dy_r <= DW'(vy_r) - DW'(prev_y_r);
    end
    if (cmd.square) begin
      sqx_r <= mag_x * mag_x;
      sqy_r <= mag_y * mag_y;
    end
    if (cmd.decide) begin
      num_r <= LW'(num_wide);
    end
    if (cmd.mul) begin
      prod_x_r <= PW'(num_r * mag_x);
      prod_y_r <= PW'(num_r * mag_y);
    end
  end

  // Update the polyline state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      run_r    <= '0;
      target_r <= '0;
      found_r  <= 1'b0;
      hit_x_r  <= '0;
      hit_y_r  <= '0;
      hit_dx_r <= '0;
      hit_dy_r <= '0;
      seen_r   <= ppad_pkg::SEEN_NONE;
    end else if (cmd.start_line) begin
      prev_x_r <= vx_r;
      prev_y_r <= vy_r;
      run_r    <= '0;
      target_r <= tgt_r;
      found_r  <= 1'b0;
      hit_x_r  <= '0;
      hit_y_r  <= '0;
      hit_dx_r <= '0;
      hit_dy_r <= '0;
      seen_r   <= last_r ? ppad_pkg::SEEN_NONE : ppad_pkg::SEEN_ONE;
    end else if (cmd.hit) begin
      hit_x_r  <= CW'(hit_x_wide);
      hit_y_r  <= CW'(hit_y_wide);
      hit_dx_r <= dx_r;
      hit_dy_r <= dy_r;
      found_r  <= 1'b1;
    end else if (cmd.commit) begin
      prev_x_r <= vx_r;
      prev_y_r <= vy_r;
      run_r    <= next_len;
      if (last_r) begin
        seen_r <= ppad_pkg::SEEN_NONE;
      end else if (seen_r != ppad_pkg::SEEN_MAX) begin
        seen_r <= seen_r + 1'b1;
      end
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_one) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_one) begin
      out_x_r  <= vx_r;
      out_y_r  <= vy_r;
      out_dx_r <= '0;
      out_dy_r <= '0;
      out_st_r <= ppad_pkg::ST_SHORT;
    end else if (cmd.emit) begin
      if (found_r) begin
        out_x_r  <= hit_x_r;
        out_y_r  <= hit_y_r;
        out_dx_r <= hit_dx_r;
        out_dy_r <= hit_dy_r;
        out_st_r <= ppad_pkg::ST_FOUND;
      end else begin
        out_x_r  <= vx_r;
        out_y_r  <= vy_r;
        out_dx_r <= dx_r;
        out_dy_r <= dy_r;
        out_st_r <= ppad_pkg::ST_CLAMPED;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign point_x   = out_x_r;
  assign point_y   = out_y_r;
  assign dir_x     = out_dx_r;
  assign dir_y     = out_dy_r;
  assign status    = out_st_r;

endmodule
`default_nettype wire

// ===== hdl/ppad_ctrl.sv =====
// Controller: sequences one vertex item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module ppad_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire ppad_pkg::sts_t sts,
  output      ppad_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SQUARE   = 4'd2;
  localparam logic [3:0] S_ROOT_GO  = 4'd3;
  localparam logic [3:0] S_ROOT     = 4'd4;
  localparam logic [3:0] S_DECIDE   = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_HIT      = 4'd9;
  localparam logic [3:0] S_COMMIT   = 4'd10;
  localparam logic [3:0] S_EMIT_ONE = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.open_line) begin
          cmd.diff  = 1'b1;
          state_nxt = S_SQUARE;
        end else begin
          cmd.start_line = 1'b1;
          state_nxt      = sts.last ? S_EMIT_ONE : S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (!sts.root_busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.hit ? S_MUL : S_COMMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_HIT;
        end
      end
      S_HIT: begin
        cmd.hit   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT_ONE: begin
        if (sts.out_free) begin
          cmd.emit_one = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/polyline_point_at_distance.sv =====
// Top level: point at a given arc length along a streamed polyline.
//
//   channel  direction  carries                                          handshake
//   in_ch    sink       vertex_x/y, target_distance, first/last_vertex   valid/ready
//   out_ch   source     point_x/y, dir_x/y, status                       valid/ready
//
// A vertex that opens a polyline goes from acceptance through S_CHECK back to ready;
// when it is also the last vertex it first loads a single-vertex result in S_EMIT_ONE.
// Every later vertex runs the difference, square, the 25-step square root of the
// segment length and the decide and commit states before ready returns; a last vertex
// also loads the result, and the one segment that passes the target adds the 24-step
// interpolation dividers (x and y run side by side).
// Reset (rst_n low, synchronous) closes any open polyline and empties the result register.
// A result waiting in the output register stalls the block only when the next
// result is ready to be loaded.
`timescale 1ns / 1ps
`default_nettype none
module polyline_point_at_distance (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppad_in_if.sink    in_ch,
  ppad_out_if.source out_ch
);

  ppad_pkg::cmd_t cmd;
  ppad_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  // Sequence each item
  ppad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold state and do the arithmetic
  ppad_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .vertex_x        (in_ch.vertex_x),
    .vertex_y        (in_ch.vertex_y),
    .target_distance (in_ch.target_distance),
    .first_vertex    (in_ch.first_vertex),
    .last_vertex     (in_ch.last_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ch.ready),
    .point_x         (out_ch.point_x),
    .point_y         (out_ch.point_y),
    .dir_x           (out_ch.dir_x),
    .dir_y           (out_ch.dir_y),
    .status          (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire

// ===== sim/polyline_point_checker.sv =====
// Checker for the polyline point block: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module polyline_point_checker
  import ppad_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ppad_in_if   in_mon,
  ppad_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    dir_t                  dx;
    dir_t                  dy;
    logic [STATUS_W-1:0]   status;
  } point_res_t;

  point_res_t expected_points[$];

  // Copy of the block state
  coord_t            prev_x, prev_y;
  dist_t             run_len, target_held;
  logic              hit_found;
  coord_t            hit_x, hit_y;
  dir_t              hit_dx, hit_dy;
  logic [SEEN_W-1:0] seen;

  // Exact integer square root, bit by bit
  function automatic longint unsigned seg_root(input longint unsigned v);
    longint unsigned rem, root, probe;
    rem   = v;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // num * d / den rounded to nearest, ties away from zero
  function automatic longint signed interp_offset(input longint unsigned num,
                                                  input longint signed d,
                                                  input longint unsigned den);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = (num * mag + den / 2) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_vertex(input coord_t vx, input coord_t vy, input dist_t tgt,
                                input logic first, input logic last);
    longint signed   dx, dy;
    longint unsigned sq, len, nxt, num;
    point_res_t      r;
    if (first || seen == SEEN_NONE) begin
      // Open a new polyline at this vertex
      prev_x      = vx;
      prev_y      = vy;
      run_len     = '0;
      target_held = tgt;
      hit_found   = 1'b0;
      hit_x       = '0;
      hit_y       = '0;
      hit_dx      = '0;
      hit_dy      = '0;
      seen        = SEEN_ONE;
      if (last) begin
        r = '{x: vx, y: vy, dx: '0, dy: '0, status: ST_SHORT};
        expected_points.push_back(r);
        seen = SEEN_NONE;
      end
    end else begin
      dx  = longint'(vx) - longint'(prev_x);
      dy  = longint'(vy) - longint'(prev_y);
      sq  = longint'(dx * dx + dy * dy);
      len = seg_root(sq);
      nxt = longint'(run_len) + len;
      if (nxt > 64'h0000_0000_FFFF_FFFF) nxt = 64'h0000_0000_FFFF_FFFF;
      // First segment that passes the target: interpolate
      if (!hit_found && nxt > longint'(target_held) && len != 0) begin
        num       = longint'(target_held) - longint'(run_len);
        hit_x     = coord_t'(longint'(prev_x) + interp_offset(num, dx, len));
        hit_y     = coord_t'(longint'(prev_y) + interp_offset(num, dy, len));
        hit_dx    = dir_t'(dx);
        hit_dy    = dir_t'(dy);
        hit_found = 1'b1;
      end
      run_len = dist_t'(nxt);
      prev_x  = vx;
      prev_y  = vy;
      if (seen != SEEN_MAX) seen = seen + 1'b1;
      if (last) begin
        if (hit_found) begin
          r = '{x: hit_x, y: hit_y, dx: hit_dx, dy: hit_dy, status: ST_FOUND};
        end else begin
          r = '{x: vx, y: vy, dx: dir_t'(dx), dy: dir_t'(dy), status: ST_CLAMPED};
        end
        expected_points.push_back(r);
        seen = SEEN_NONE;
      end
    end
  endtask

  // Compare accepted results, then predict from accepted items
  always @(posedge clk) begin
    point_res_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      expected_points.delete();
      prev_x      = '0;
      prev_y      = '0;
      run_len     = '0;
      target_held = '0;
      hit_found   = 1'b0;
      hit_x       = '0;
      hit_y       = '0;
      hit_dx      = '0;
      hit_dy      = '0;
      seen        = SEEN_NONE;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t unexpected item: point %0d,%0d dir %0d,%0d status %0d", $time,
                   out_mon.point_x, out_mon.point_y, out_mon.dir_x, out_mon.dir_y,
                   out_mon.status);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (out_mon.point_x !== want.x) begin
            $display("%0t point_x expected %0d actual %0d", $time, want.x, out_mon.point_x);
            errs++;
          end
          if (out_mon.point_y !== want.y) begin
            $display("%0t point_y expected %0d actual %0d", $time, want.y, out_mon.point_y);
            errs++;
          end
          if (out_mon.dir_x !== want.dx) begin
            $display("%0t dir_x expected %0d actual %0d", $time, want.dx, out_mon.dir_x);
            errs++;
          end
          if (out_mon.dir_y !== want.dy) begin
            $display("%0t dir_y expected %0d actual %0d", $time, want.dy, out_mon.dir_y);
            errs++;
          end
          if (out_mon.status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status,
                     out_mon.status);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_vertex(in_mon.vertex_x, in_mon.vertex_y, in_mon.target_distance,
                       in_mon.first_vertex, in_mon.last_vertex);
      fail_count <= fail_count + errs;
      pending    <= expected_points.size();
    end
  end

endmodule

// ===== sim/tb_polyline_point_at_distance.sv =====
// Testbench top: drives polylines into the block, throttles results and reports the verdict.
`timescale 1ns / 1ps
module tb_polyline_point_at_distance;
  import ppad_pkg::*;

  localparam int COORD_MIN = -8388608;
  localparam int COORD_MAX = 8388607;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic rx_ready = 1'b0;
  logic calm     = 1'b0;
  int   rx_left  = 0;
  int   items_sent = 0;
  int   fail_count;
  int   pending;

  ppad_in_if  in_ch ();
  ppad_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  polyline_point_at_distance i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  polyline_point_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready in random bursts, always high once calm
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      rx_ready <= 1'b1;
      rx_left  <= 0;
    end else if (rx_left == 0) begin
      rx_ready <= ($urandom_range(0, 2) != 0);
      rx_left  <= $urandom_range(1, 17);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Offer one item, with an optional gap ahead of it, and hold until accepted
  task automatic send_vertex(input int x, input int y, input dist_t tgt,
                             input logic first, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.vertex_x        <= coord_t'(x);
    in_ch.vertex_y        <= coord_t'(y);
    in_ch.target_distance <= tgt;
    in_ch.first_vertex    <= first;
    in_ch.last_vertex     <= last;
    in_ch.valid           <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has come
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // One random polyline: mostly well formed, some single, abandoned or unmarked
  task automatic send_polyline();
    int     n, kind, span, x, y, i, pick;
    coord_t cx, cy;
    dist_t  tgt;
    logic   first, last;
    kind = $urandom_range(0, 99);
    n    = (kind >= 70 && kind < 78) ? 1 : $urandom_range(2, 6);
    case ($urandom_range(0, 4))
      0:       span = 255;
      1:       span = 1 << 12;
      2:       span = 1 << 16;
      3:       span = 1 << 20;
      default: span = 1 << 24;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0)      tgt = '0;
    else if (pick == 1) tgt = '1;
    else if (pick < 4)  tgt = $urandom;
    else                tgt = $urandom_range(0, (n > 1 ? n - 1 : 1) * span);
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    x  = cx;
    y  = cy;
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) begin
        if (span == (1 << 24)) begin
          cx = coord_t'($urandom);
          cy = coord_t'($urandom);
          x  = cx;
          y  = cy;
        end else begin
          x = clamp_coord(x + $urandom_range(0, 2 * span) - span);
          y = clamp_coord(y + $urandom_range(0, 2 * span) - span);
        end
      end
      // First mark left off on unmarked polylines; last mark dropped on abandoned ones
      first = (i == 0) && !(kind >= 89);
      last  = (i == n - 1) && !(kind >= 78 && kind < 89);
      send_vertex(x, y, (i == 0) ? tgt : dist_t'($urandom), first, last);
    end
  endtask

  initial begin
    #(20_000_000);
    $display("polyline_point_at_distance: mismatch");
    $finish;
  end

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.vertex_x        <= '0;
    in_ch.vertex_y        <= '0;
    in_ch.target_distance <= '0;
    in_ch.first_vertex    <= 1'b0;
    in_ch.last_vertex     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single vertex at the coordinate extremes
    send_vertex(COORD_MAX, COORD_MIN, 32'd0, 1'b1, 1'b1);
    // Full-range diagonal: target zero, then target never reached, then a target inside the reversed diagonal
    send_vertex(COORD_MIN, COORD_MIN, 32'd0, 1'b1, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 32'd0, 1'b0, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 32'd0, 1'b0, 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, 32'h0100_0000, 1'b1, 1'b0);
    send_vertex(COORD_MIN, COORD_MIN, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // Target exactly at the end, then just short of it
    send_vertex(0, 0, 32'd1280, 1'b1, 1'b0);
    send_vertex(768, 1024, 32'd0, 1'b0, 1'b1);
    send_vertex(0, 0, 32'd1279, 1'b1, 1'b0);
    send_vertex(768, 1024, 32'd0, 1'b0, 1'b1);
    // Zero-length segment ahead of the passing one
    send_vertex(100, 100, 32'd128, 1'b1, 1'b0);
    send_vertex(100, 100, 32'd0, 1'b0, 1'b0);
    send_vertex(356, 100, 32'd0, 1'b0, 1'b1);
    // Polyline opened without a first mark
    send_vertex(10, 20, 32'd5, 1'b0, 1'b0);
    send_vertex(-300, 20, 32'd0, 1'b0, 1'b1);
    // First mark inside an open polyline abandons it
    send_vertex(0, 0, 32'd1000, 1'b1, 1'b0);
    send_vertex(500, 0, 32'd0, 1'b0, 1'b0);
    send_vertex(0, 0, 32'd10, 1'b1, 1'b0);
    send_vertex(0, 256, 32'd0, 1'b0, 1'b1);
    // Rounding tie on a negative direction
    send_vertex(0, 0, 32'd1, 1'b1, 1'b0);
    send_vertex(-1, -2, 32'd0, 1'b0, 1'b1);
    drain_results();

    // Random polylines; quiet toward the end
    while (items_sent < 900) begin
      if (items_sent > 400 && items_sent < 410) drain_results();
      if (items_sent > 770) calm <= 1'b1;
      send_polyline();
    end
    drain_results();
    repeat (100) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("polyline_point_at_distance: match");
    else
      $display("polyline_point_at_distance: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ppad_pkg.sv
hdl/ppad_in_if.sv
hdl/ppad_out_if.sv
hdl/ppad_sqrt.sv
hdl/ppad_div.sv
hdl/ppad_dp.sv
hdl/ppad_ctrl.sv
hdl/polyline_point_at_distance.sv
sim/polyline_point_checker.sv
sim/tb_polyline_point_at_distance.sv
